FILE: rtl/hvf_pkg.sv
// Package: types, constants and codes shared by the header filter modules.
`default_nettype none
package hvf_pkg;

  localparam int unsigned MAX_NEST         = 4;
  localparam int unsigned MAX_PACKET_BYTES = 16384;
  localparam int unsigned OFF_W            = $clog2(MAX_PACKET_BYTES + 128);
  localparam int unsigned NEST_W           = 3;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [3:0]  IP_VERSION4    = 4'h4;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;

  localparam int unsigned ETH_HDR_BYTES = 14;
  localparam int unsigned TUNNEL_SKIP   = 16;
  localparam int unsigned REL_ETYPE_HI  = 12;
  localparam int unsigned REL_ETYPE_LO  = 13;
  localparam int unsigned REL_VIHL      = 14;
  localparam int unsigned REL_FRAG_HI   = 20;
  localparam int unsigned REL_FRAG_LO   = 21;
  localparam int unsigned REL_PROTO     = 23;
  localparam int unsigned REL_DADDR_LO  = 30;
  localparam int unsigned REL_DADDR_HI  = 33;

  localparam logic [23:0] PHYS_PREFIX_RST = 24'hc0a800;
  localparam logic [15:0] VIRT_PREFIX_RST = 16'h0ae9;
  localparam logic [15:0] TUNNEL_PORT_RST = 16'd4789;

  typedef enum logic [7:0] {
    REG_PHYS_PREFIX = 8'd0,
    REG_VIRT_PREFIX = 8'd1,
    REG_DEEP_MODE   = 8'd2,
    REG_TUNNEL_PORT = 8'd3
  } reg_index_e;

  typedef enum logic [2:0] {
    RSN_OK        = 3'd0,
    RSN_ETHERTYPE = 3'd1,
    RSN_VERSION   = 3'd2,
    RSN_ADDRESS   = 3'd3,
    RSN_FRAGMENT  = 3'd4,
    RSN_PROTOCOL  = 3'd5,
    RSN_TRUNCATED = 3'd6,
    RSN_NEST      = 3'd7
  } reason_e;

  typedef enum logic [1:0] {
    STG_ETH = 2'd0,
    STG_IP  = 2'd1,
    STG_L4  = 2'd2
  } parse_stage_e;

  typedef struct packed {
    logic [7:0] pkt_byte;
    logic       end_of_packet;
  } in_item_t;

  typedef struct packed {
    logic       accepted;
    logic [2:0] reason;
    logic [2:0] tunnel_depth;
  } out_item_t;

  typedef struct packed {
    logic [23:0] phys_net_prefix;
    logic [15:0] virt_net_prefix;
    logic        deep_mode;
    logic [15:0] tunnel_udp_port;
  } cfg_t;

endpackage
`default_nettype wire

FILE: rtl/ipv4_vxlan_header_filter_core.sv
// Top level: configuration registers, byte queue and header parser.
// Throughput: one packet byte per cycle while the verdict output is not stalled; the parser retires one byte a cycle.
// A verdict is registered in the output register once its last byte has passed through the
// queue and been popped by the parser, so it passes the queue and then the output register.
// The queue holds four bytes; a stalled verdict backs bytes up only at the next last byte.
// Reset: asynchronous, active low; clears queue, parse state and output valid, loads register defaults.
`default_nettype none
module ipv4_vxlan_header_filter_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire hvf_pkg::in_item_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output hvf_pkg::out_item_t      out_data_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [7:0]         cfg_index_i,
  input  wire logic [31:0]        cfg_data_i
);

  hvf_pkg::cfg_t     cfg_q;
  logic              q_valid, q_pop;
  hvf_pkg::in_item_t q_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.phys_net_prefix <= hvf_pkg::PHYS_PREFIX_RST;
      cfg_q.virt_net_prefix <= hvf_pkg::VIRT_PREFIX_RST;
      cfg_q.deep_mode       <= 1'b0;
      cfg_q.tunnel_udp_port <= hvf_pkg::TUNNEL_PORT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        hvf_pkg::REG_PHYS_PREFIX: cfg_q.phys_net_prefix <= cfg_data_i[23:0];
        hvf_pkg::REG_VIRT_PREFIX: cfg_q.virt_net_prefix <= cfg_data_i[15:0];
        hvf_pkg::REG_DEEP_MODE:   cfg_q.deep_mode       <= cfg_data_i[0];
        hvf_pkg::REG_TUNNEL_PORT: cfg_q.tunnel_udp_port <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  hvf_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_valid_i),
    .push_stall_o (in_stall_o),
    .push_data_i  (in_data_i),
    .pop_valid_o  (q_valid),
    .pop_i        (q_pop),
    .pop_data_o   (q_data)
  );

  hvf_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .byte_valid_i (q_valid),
    .byte_i       (q_data),
    .byte_pop_o   (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule
`default_nettype wire

FILE: rtl/hvf_queue.sv
// Front queue: accepts packet bytes and buffers them for the parser.
`default_nettype none
module hvf_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_valid_i,
  output logic                   push_stall_o,
  input  wire hvf_pkg::in_item_t push_data_i,
  output logic                   pop_valid_o,
  input  wire logic              pop_i,
  output hvf_pkg::in_item_t      pop_data_o
);

  hvf_pkg::in_item_t                mem_q [hvf_pkg::QUEUE_DEPTH];
  logic [hvf_pkg::QUEUE_AW-1:0]     wptr_q, wptr_d, rptr_q, rptr_d;
  logic [hvf_pkg::QUEUE_AW:0]       cnt_q, cnt_d;
  logic                             push, pop;

  assign push_stall_o = (cnt_q == (hvf_pkg::QUEUE_AW + 1)'(hvf_pkg::QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rptr_q];
  assign push         = push_valid_i && !push_stall_o;
  assign pop          = pop_i && pop_valid_o;

  always_comb begin
    wptr_d = push ? wptr_q + 1'b1 : wptr_q;
    rptr_d = pop ? rptr_q + 1'b1 : rptr_q;
    cnt_d  = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/hvf_parser.sv
// Back end: walks the header layers byte by byte and registers the verdict.
`default_nettype none
module hvf_parser (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire hvf_pkg::cfg_t     cfg_i,
  input  wire logic              byte_valid_i,
  input  wire hvf_pkg::in_item_t byte_i,
  output logic                   byte_pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output hvf_pkg::out_item_t     out_data_o
);

  localparam int unsigned OW = hvf_pkg::OFF_W;

  logic [OW-1:0]                 off_q, off_d, base_q, base_d, rel, l4;
  hvf_pkg::parse_stage_e         stage_q, stage_d;
  logic [15:0]                   etype_q, etype_d, frag_q, frag_d, port_q, port_d;
  logic [7:0]                    vihl_q, vihl_d, proto_q, proto_d;
  logic [31:0]                   daddr_q, daddr_d;
  logic [hvf_pkg::NEST_W-1:0]    nest_q, nest_d;
  hvf_pkg::reason_e              code_q, code_d;
  logic                          done_q, done_d;
  logic                          active, decide, eop, pop;
  logic [7:0]                    b;
  logic                          out_valid_q;
  hvf_pkg::out_item_t            out_data_q, res;
  hvf_pkg::reason_e              res_code;

  assign b    = byte_i.pkt_byte;
  assign eop  = byte_i.end_of_packet;
  assign pop  = byte_valid_i && (!eop || !out_valid_q || !out_stall_i);
  assign byte_pop_o = pop;
  assign rel  = off_q - base_q;
  assign l4   = OW'(hvf_pkg::ETH_HDR_BYTES) + OW'({vihl_q[3:0], 2'b00});
  assign active = !done_q && (off_q < OW'(hvf_pkg::MAX_PACKET_BYTES)) && (off_q >= base_q);

  always_comb begin
    off_d   = off_q;
    base_d  = base_q;
    stage_d = stage_q;
    etype_d = etype_q;
    vihl_d  = vihl_q;
    frag_d  = frag_q;
    proto_d = proto_q;
    daddr_d = daddr_q;
    port_d  = port_q;
    nest_d  = nest_q;
    code_d  = code_q;
    done_d  = done_q;
    decide  = 1'b0;
    if (pop) begin
      if (off_q < OW'(hvf_pkg::MAX_PACKET_BYTES)) begin
        off_d = off_q + 1'b1;
      end
      if (active) begin
        if (stage_q != hvf_pkg::STG_ETH && rel != OW'(hvf_pkg::REL_VIHL)) begin
          if (rel == l4 + OW'(2)) begin
            port_d[15:8] = b;
          end else if (rel == l4 + OW'(3)) begin
            port_d[7:0] = b;
          end
        end
        case (stage_q)
          hvf_pkg::STG_ETH: begin
            if (rel == OW'(hvf_pkg::REL_ETYPE_HI)) begin
              etype_d[15:8] = b;
            end else if (rel == OW'(hvf_pkg::REL_ETYPE_LO)) begin
              etype_d[7:0] = b;
              if ({etype_q[15:8], b} != hvf_pkg::ETHERTYPE_IPV4) begin
                code_d = hvf_pkg::RSN_ETHERTYPE;
                done_d = 1'b1;
              end else begin
                stage_d = hvf_pkg::STG_IP;
              end
            end
          end
          hvf_pkg::STG_IP: begin
            if (rel == OW'(hvf_pkg::REL_VIHL)) begin
              vihl_d = b;
              if (b[7:4] != hvf_pkg::IP_VERSION4) begin
                code_d = hvf_pkg::RSN_VERSION;
                done_d = 1'b1;
              end
            end else begin
              if (rel == OW'(hvf_pkg::REL_FRAG_HI)) begin
                frag_d[15:8] = b;
              end else if (rel == OW'(hvf_pkg::REL_FRAG_LO)) begin
                frag_d[7:0] = b;
              end else if (rel == OW'(hvf_pkg::REL_PROTO)) begin
                proto_d = b;
              end else if (rel >= OW'(hvf_pkg::REL_DADDR_LO) &&
                           rel <= OW'(hvf_pkg::REL_DADDR_HI)) begin
                daddr_d = {daddr_q[23:0], b};
              end
              if (rel == OW'(hvf_pkg::REL_DADDR_HI)) begin
                if (daddr_d[31:8] != cfg_i.phys_net_prefix &&
                    daddr_d[31:16] != cfg_i.virt_net_prefix) begin
                  code_d = hvf_pkg::RSN_ADDRESS;
                  done_d = 1'b1;
                end else if (frag_q[12:0] != '0) begin
                  code_d = hvf_pkg::RSN_FRAGMENT;
                  done_d = 1'b1;
                end else if (proto_q != hvf_pkg::PROTO_UDP &&
                             proto_q != hvf_pkg::PROTO_TCP) begin
                  code_d = hvf_pkg::RSN_PROTOCOL;
                  done_d = 1'b1;
                end else if (!cfg_i.deep_mode || proto_q != hvf_pkg::PROTO_UDP) begin
                  code_d = hvf_pkg::RSN_OK;
                  done_d = 1'b1;
                end else if (l4 + OW'(3) <= OW'(hvf_pkg::REL_DADDR_HI)) begin
                  decide = 1'b1;
                end else begin
                  stage_d = hvf_pkg::STG_L4;
                end
              end
            end
          end
          hvf_pkg::STG_L4: begin
            if (rel == l4 + OW'(3)) begin
              decide = 1'b1;
            end
          end
          default: ;
        endcase
        if (decide) begin
          if (cfg_i.deep_mode && proto_q == hvf_pkg::PROTO_UDP &&
              port_d == cfg_i.tunnel_udp_port) begin
            if (nest_q >= hvf_pkg::NEST_W'(hvf_pkg::MAX_NEST)) begin
              code_d = hvf_pkg::RSN_NEST;
              done_d = 1'b1;
            end else begin
              nest_d  = nest_q + 1'b1;
              base_d  = base_q + l4 + OW'(hvf_pkg::TUNNEL_SKIP);
              stage_d = hvf_pkg::STG_ETH;
              etype_d = '0;
              vihl_d  = '0;
              frag_d  = '0;
              proto_d = '0;
              daddr_d = '0;
              port_d  = '0;
            end
          end else begin
            code_d = hvf_pkg::RSN_OK;
            done_d = 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    res_code         = done_d ? code_d : hvf_pkg::RSN_TRUNCATED;
    res.accepted     = (res_code == hvf_pkg::RSN_OK);
    res.reason       = res_code;
    res.tunnel_depth = nest_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q   <= '0;
      base_q  <= '0;
      stage_q <= hvf_pkg::STG_ETH;
      etype_q <= '0;
      vihl_q  <= '0;
      frag_q  <= '0;
      proto_q <= '0;
      daddr_q <= '0;
      port_q  <= '0;
      nest_q  <= '0;
      code_q  <= hvf_pkg::RSN_TRUNCATED;
      done_q  <= 1'b0;
    end else if (pop && eop) begin
      off_q   <= '0;
      base_q  <= '0;
      stage_q <= hvf_pkg::STG_ETH;
      etype_q <= '0;
      vihl_q  <= '0;
      frag_q  <= '0;
      proto_q <= '0;
      daddr_q <= '0;
      port_q  <= '0;
      nest_q  <= '0;
      code_q  <= hvf_pkg::RSN_TRUNCATED;
      done_q  <= 1'b0;
    end else begin
      off_q   <= off_d;
      base_q  <= base_d;
      stage_q <= stage_d;
      etype_q <= etype_d;
      vihl_q  <= vihl_d;
      frag_q  <= frag_d;
      proto_q <= proto_d;
      daddr_q <= daddr_d;
      port_q  <= port_d;
      nest_q  <= nest_d;
      code_q  <= code_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop && eop) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && eop) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
`default_nettype wire

FILE: rtl/hvf_checker.sv
// Checker: port-level properties of the header filter, bound to the top level.
`default_nettype none
module hvf_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire hvf_pkg::in_item_t  in_data_i,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire hvf_pkg::out_item_t out_data_o
);

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i))
    else $error("stalled request changed");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled verdict changed");

  a_accept_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.accepted == (out_data_o.reason == hvf_pkg::RSN_OK)))
    else $error("accepted flag disagrees with reason");

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.tunnel_depth <= 3'(hvf_pkg::MAX_NEST))
    else $error("tunnel depth beyond nesting bound");

  a_nest_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.reason == hvf_pkg::RSN_NEST
      |-> out_data_o.tunnel_depth == 3'(hvf_pkg::MAX_NEST))
    else $error("nest limit reported below bound");

endmodule

bind ipv4_vxlan_header_filter_core hvf_checker u_hvf_checker (.*);
`default_nettype wire

FILE: dv/hvf_tb_pkg.sv
// Verdict scoreboard for the header filter testbench: byte-level predictor and result check.
package hvf_tb_pkg;
  import hvf_pkg::*;

  class header_verdict_board;
    logic [23:0] phys_prefix;
    logic [15:0] virt_prefix;
    logic        deep_on;
    logic [15:0] tunnel_port;

    int unsigned  offset;
    int unsigned  base;
    parse_stage_e stage;
    logic [15:0]  etype;
    logic [7:0]   vihl;
    logic [15:0]  frag;
    logic [7:0]   proto;
    logic [31:0]  daddr;
    logic [15:0]  dport;
    logic [2:0]   depth;
    reason_e      verdict;
    bit           decided;

    out_item_t   verdicts_due[$];
    int unsigned failures;
    int unsigned reported;

    function new();
      phys_prefix = PHYS_PREFIX_RST;
      virt_prefix = VIRT_PREFIX_RST;
      deep_on     = 1'b0;
      tunnel_port = TUNNEL_PORT_RST;
      failures    = 0;
      reported    = 0;
      clear_packet();
    endfunction

    function void write_register(logic [7:0] idx, logic [31:0] data);
      case (idx)
        REG_PHYS_PREFIX: phys_prefix = data[23:0];
        REG_VIRT_PREFIX: virt_prefix = data[15:0];
        REG_DEEP_MODE:   deep_on     = data[0];
        REG_TUNNEL_PORT: tunnel_port = data[15:0];
        default: ;
      endcase
    endfunction

    function void clear_packet();
      offset  = 0;
      base    = 0;
      stage   = STG_ETH;
      etype   = '0;
      vihl    = '0;
      frag    = '0;
      proto   = '0;
      daddr   = '0;
      dport   = '0;
      depth   = '0;
      verdict = RSN_TRUNCATED;
      decided = 1'b0;
    endfunction

    function void settle(reason_e r);
      verdict = r;
      decided = 1'b1;
    endfunction

    function int unsigned transport_start();
      return ETH_HDR_BYTES + 4 * vihl[3:0];
    endfunction

    function void decide_transport();
      if (deep_on && proto == PROTO_UDP && dport == tunnel_port) begin
        if (depth >= MAX_NEST) begin
          settle(RSN_NEST);
          return;
        end
        depth = depth + 3'd1;
        base  = base + transport_start() + TUNNEL_SKIP;
        stage = STG_ETH;
        etype = '0;
        vihl  = '0;
        frag  = '0;
        proto = '0;
        daddr = '0;
        dport = '0;
      end else begin
        settle(RSN_OK);
      end
    endfunction

    function void parse_byte(logic [7:0] b);
      int unsigned rel;
      int unsigned l4;
      if (decided || offset >= MAX_PACKET_BYTES || offset < base) return;
      rel = offset - base;
      if (stage == STG_ETH) begin
        if (rel == REL_ETYPE_HI) begin
          etype[15:8] = b;
        end else if (rel == REL_ETYPE_LO) begin
          etype[7:0] = b;
          if (etype != ETHERTYPE_IPV4) settle(RSN_ETHERTYPE);
          else stage = STG_IP;
        end
        return;
      end
      if (stage == STG_IP && rel == REL_VIHL) begin
        vihl = b;
        if (b[7:4] != IP_VERSION4) settle(RSN_VERSION);
        return;
      end
      l4 = transport_start();
      if (rel == l4 + 2) dport[15:8] = b;
      else if (rel == l4 + 3) dport[7:0] = b;
      if (stage == STG_IP) begin
        if (rel == REL_FRAG_HI) frag[15:8] = b;
        else if (rel == REL_FRAG_LO) frag[7:0] = b;
        else if (rel == REL_PROTO) proto = b;
        else if (rel >= REL_DADDR_LO && rel <= REL_DADDR_HI) daddr = {daddr[23:0], b};
        if (rel == REL_DADDR_HI) begin
          if (daddr[31:8] != phys_prefix && daddr[31:16] != virt_prefix) settle(RSN_ADDRESS);
          else if (frag[12:0] != '0) settle(RSN_FRAGMENT);
          else if (proto != PROTO_UDP && proto != PROTO_TCP) settle(RSN_PROTOCOL);
          else if (!deep_on || proto != PROTO_UDP) settle(RSN_OK);
          else if (l4 + 3 <= REL_DADDR_HI) decide_transport();
          else stage = STG_L4;
        end
        return;
      end
      if (stage == STG_L4 && rel == l4 + 3) decide_transport();
    endfunction

    function void absorb_byte(in_item_t it);
      out_item_t v;
      reason_e   code;
      parse_byte(it.pkt_byte);
      if (offset < MAX_PACKET_BYTES) offset++;
      if (it.end_of_packet) begin
        code           = decided ? verdict : RSN_TRUNCATED;
        v.accepted     = (code == RSN_OK);
        v.reason       = code;
        v.tunnel_depth = depth;
        verdicts_due.push_back(v);
        clear_packet();
      end
    endfunction

    function int unsigned pending();
      return verdicts_due.size();
    endfunction

    function void flag(string what);
      failures++;
      if (reported < 10) begin
        reported++;
        $display("%t: %s", $realtime, what);
      end
    endfunction

    function void check_verdict(out_item_t got);
      out_item_t exp;
      if (verdicts_due.size() == 0) begin
        flag($sformatf("unexpected verdict accepted=%0d reason=%0d depth=%0d",
                       got.accepted, got.reason, got.tunnel_depth));
        return;
      end
      exp = verdicts_due.pop_front();
      if (got.accepted !== exp.accepted || got.reason !== exp.reason ||
          got.tunnel_depth !== exp.tunnel_depth) begin
        flag($sformatf("verdict mismatch: expected accepted=%0d reason=%0d depth=%0d, got accepted=%0d reason=%0d depth=%0d",
                       exp.accepted, exp.reason, exp.tunnel_depth,
                       got.accepted, got.reason, got.tunnel_depth));
      end
    endfunction
  endclass

endpackage

FILE: dv/tb.sv
// Testbench top: drives packet bytes and register writes into the header filter and checks verdicts.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hvf_pkg::*;
  import hvf_tb_pkg::*;

  localparam int unsigned BYTE_TARGET   = 1350;
  localparam int unsigned MIN_PACKETS   = 10;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT   = 400000;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  in_item_t    in_data_i   = '0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i  = '0;

  header_verdict_board sb;

  logic [7:0]  frame[$];
  int unsigned frame_floor;
  int unsigned in_idle_pct   = 28;
  int unsigned out_idle_pct  = 28;
  int unsigned hold_requests = 0;
  int unsigned hold_served   = 0;
  int unsigned hold_left     = 0;
  int unsigned cycle_count   = 0;

  ipv4_vxlan_header_filter_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) sb.check_verdict(out_data_o);
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < out_idle_pct);
    end
  end

  task automatic send_byte(logic [7:0] b, logic last);
    in_item_t it;
    it.pkt_byte      = b;
    it.end_of_packet = last;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    sb.absorb_byte(it);
  endtask

  task automatic send_frame();
    for (int unsigned i = 0; i < frame.size(); i++) send_byte(frame[i], i == frame.size() - 1);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_register(idx, data);
  endtask

  task automatic apply_setting(int unsigned phase);
    logic [23:0] phys;
    logic [15:0] virt;
    logic [15:0] port;
    logic        deep;
    case (phase)
      0: begin
        phys = PHYS_PREFIX_RST; virt = VIRT_PREFIX_RST; deep = 1'b1; port = TUNNEL_PORT_RST;
      end
      1: begin
        phys = '0; virt = '0; deep = 1'b1; port = '0;
      end
      2: begin
        phys = '1; virt = '1; deep = 1'b1; port = '1;
      end
      3: begin
        phys = PHYS_PREFIX_RST; virt = VIRT_PREFIX_RST; deep = 1'b0; port = TUNNEL_PORT_RST;
      end
      default: begin
        phys = 24'($urandom);
        virt = 16'($urandom);
        deep = ($urandom_range(3) != 0);
        port = 16'($urandom);
      end
    endcase
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    write_reg(REG_PHYS_PREFIX, {8'($urandom), phys});
    write_reg(REG_VIRT_PREFIX, {16'($urandom), virt});
    write_reg(REG_DEEP_MODE, {31'($urandom), deep});
    write_reg(REG_TUNNEL_PORT, {16'($urandom), port});
    write_reg(8'(REG_TUNNEL_PORT) + 8'($urandom_range(1, 252)), $urandom);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic void grow_to(int unsigned n);
    while (frame.size() < n) frame.push_back(8'($urandom));
  endfunction

  function automatic void put_byte(int unsigned pos, logic [7:0] v);
    grow_to(pos + 1);
    if (pos >= frame_floor) frame[pos] = v;
  endfunction

  function automatic void build_noise(int unsigned len);
    frame.delete();
    frame_floor = 0;
    grow_to(len);
  endfunction

  function automatic void build_frame(int unsigned tunnels, bit clean);
    int unsigned base;
    int unsigned l4;
    bit          inner;
    logic [15:0] etype;
    logic [15:0] frag;
    logic [15:0] port;
    logic [7:0]  vihl;
    logic [7:0]  proto;
    logic [31:0] daddr;
    frame.delete();
    frame_floor = 0;
    base = 0;
    for (int unsigned lvl = 0; lvl <= tunnels; lvl++) begin
      inner = clean && (lvl < tunnels);
      etype = (inner || $urandom_range(9) != 0) ? ETHERTYPE_IPV4 : 16'($urandom);
      if (inner) begin
        vihl = ($urandom_range(9) < 7) ? {IP_VERSION4, 4'd5}
                                        : {IP_VERSION4, 4'($urandom_range(6, 15))};
      end else begin
        case ($urandom_range(9))
          0, 1, 2, 3, 4, 5, 6: vihl = {IP_VERSION4, 4'd5};
          7: vihl = {IP_VERSION4, 4'($urandom)};
          8: vihl = {IP_VERSION4, 4'($urandom_range(6, 15))};
          default: vihl = 8'($urandom);
        endcase
      end
      if (inner) begin
        frag = '0;
      end else begin
        case ($urandom_range(9))
          0, 1, 2, 3: frag = 16'h0000;
          4, 5: frag = 16'h4000;
          6: frag = 16'h2000;
          7: frag = {3'($urandom), 13'($urandom_range(1, 8191))};
          8: frag = 16'h0001;
          default: frag = 16'($urandom);
        endcase
      end
      case (inner ? $urandom_range(7) : $urandom_range(9))
        0, 1, 2, 3, 4: daddr = {sb.phys_prefix, 8'($urandom)};
        5, 6, 7: daddr = {sb.virt_prefix, 16'($urandom)};
        default: daddr = 32'($urandom);
      endcase
      case (inner ? 0 : $urandom_range(9))
        0, 1, 2, 3, 4, 5: proto = PROTO_UDP;
        6, 7: proto = PROTO_TCP;
        default: proto = 8'($urandom);
      endcase
      port = (inner || $urandom_range(9) < 6) ? sb.tunnel_port : 16'($urandom);

      for (int unsigned i = 0; i < REL_ETYPE_HI; i++) put_byte(base + i, 8'($urandom));
      put_byte(base + REL_ETYPE_HI, etype[15:8]);
      put_byte(base + REL_ETYPE_LO, etype[7:0]);
      put_byte(base + REL_VIHL, vihl);
      put_byte(base + REL_FRAG_HI, frag[15:8]);
      put_byte(base + REL_FRAG_LO, frag[7:0]);
      put_byte(base + REL_PROTO, proto);
      for (int unsigned k = 0; k < 4; k++) put_byte(base + REL_DADDR_LO + k, daddr[31 - 8 * k -: 8]);
      l4 = ETH_HDR_BYTES + 4 * vihl[3:0];
      put_byte(base + l4 + 2, port[15:8]);
      put_byte(base + l4 + 3, port[7:0]);
      grow_to(base + l4 + TUNNEL_SKIP);
      if (lvl < tunnels) begin
        frame_floor = base + REL_DADDR_HI + 1;
        base = base + l4 + TUNNEL_SKIP;
      end
    end
    grow_to(frame.size() + $urandom_range(0, 24));
  endfunction

  initial begin
    int unsigned pkt_count;
    int unsigned byte_count;
    int unsigned tunnels;
    int unsigned cut;
    sb = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b1);
    for (int i = 0; i < REL_ETYPE_HI; i++) send_byte(i[0] ? 8'hFF : 8'h00, 1'b0);
    send_byte(8'h86, 1'b0);
    send_byte(8'hDD, 1'b1);

    byte_count = 16;
    pkt_count  = 0;
    while (byte_count < BYTE_TARGET || pkt_count < MIN_PACKETS) begin
      if (pkt_count % 3 == 2) apply_setting(pkt_count / 3);
      if (pkt_count == 4) begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end
      if (pkt_count == 8) begin
        in_idle_pct  = 28;
        out_idle_pct = 28;
      end
      if (pkt_count == 3) begin
        hold_requests++;
        for (int k = 0; k < 16; k++) begin
          build_noise($urandom_range(1, 3));
          byte_count += frame.size();
          send_frame();
        end
      end
      if ($urandom_range(99) < 8) begin
        build_noise($urandom_range(1, 40));
        byte_count += frame.size();
      end else begin
        case ($urandom_range(9))
          0, 1, 2, 3: tunnels = 0;
          4, 5: tunnels = 1;
          6: tunnels = 2;
          7: tunnels = 3;
          8: tunnels = MAX_NEST;
          default: tunnels = MAX_NEST + 1;
        endcase
        build_frame(tunnels, $urandom_range(3) != 0);
        if ($urandom_range(99) < 12) begin
          cut = $urandom_range(1, frame.size());
          frame = frame[0:cut - 1];
        end
        byte_count += frame.size();
      end
      send_frame();
      pkt_count++;
    end

    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
